// ===== src/zfs_pkg.sv =====
// ----------------------------------------------------------------------------
// zfs_pkg: shared types and constants of the zero-padded FIR smoother
// Sizes of the window, the arithmetic and the queues, plus the job and
// result records that travel between the front, the job queue and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package zfs_pkg;

   // filter geometry
   localparam int RADIUS      = 3;
   localparam int SAMPLE_BITS = 16;
   localparam int WIN_LEN     = 2 * RADIUS + 1;

   // coefficient registers: fixed at seven Q1.15 taps
   localparam int NUM_TAPS     = 7;
   localparam int TAP_MID      = 3;
   localparam int COEF_BITS    = 16;
   localparam int CSR_IDX_BITS = $clog2(NUM_TAPS);
   localparam int FRAC_BITS    = 15;

   // arithmetic widths
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS  = PROD_BITS + $clog2(WIN_LEN);

   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(1 << (FRAC_BITS - 1));
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_BITS-1:0] SAT_LO =
      ACC_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   // batch position counters
   localparam int SEEN_BITS = $clog2(RADIUS + 1);

   // queues
   localparam int JOBQ_DEPTH    = 4;
   localparam int JOBQ_PTR_BITS = $clog2(JOBQ_DEPTH);
   localparam int JOBQ_CNT_BITS = $clog2(JOBQ_DEPTH + 1);
   localparam int OUT_DEPTH     = 4;
   localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);

   // front sequencer
   typedef enum logic {
      FRONT_RUN,
      FRONT_FLUSH
   } front_state_type;

   // one dot product to compute: window newest first, plus result flags
   typedef struct packed {
      logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] win;
      logic                                batch_end;
      logic                                run_end;
   } job_type;

   // one finished result
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] smoothed;
      logic                   batch_end;
      logic                   run_end;
   } result_type;

   // reset value of a coefficient register: unity at the center, zero elsewhere
   function automatic logic [COEF_BITS-1:0] tap_reset(input int idx);
      logic [COEF_BITS-1:0] val;
      val = '0;
      if (idx == TAP_MID) begin
         val = COEF_BITS'(32767);
      end
      return val;
   endfunction

endpackage

// ===== src/zfs_jobq.sv =====
// ----------------------------------------------------------------------------
// zfs_jobq: job queue between front and back
// Small circular buffer of window snapshots; lets the front and the back
// stall independently of each other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zfs_jobq (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  zfs_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output zfs_pkg::job_type pop_job,
   output logic             empty
);

   zfs_pkg::job_type mem [zfs_pkg::JOBQ_DEPTH];

   logic [zfs_pkg::JOBQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [zfs_pkg::JOBQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [zfs_pkg::JOBQ_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                              do_push, do_pop;

   assign full    = (cnt_ff == zfs_pkg::JOBQ_CNT_BITS'(zfs_pkg::JOBQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   // the front never offers a job into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into full queue");

endmodule

// ===== src/zfs_front.sv =====
// ----------------------------------------------------------------------------
// zfs_front: sample intake and job issue
// Keeps the sample window and the batch position, and issues one window
// snapshot per result; at a batch end shifts in zeros to flush the tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zfs_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic signed [zfs_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                   req_final_sample,
   output logic                                   job_push,
   output zfs_pkg::job_type                       job,
   input  logic                                   job_full
);

   zfs_pkg::front_state_type state_ff, state_in;

   logic [zfs_pkg::WIN_LEN-1:0][zfs_pkg::SAMPLE_BITS-1:0] win_ff, win_in;
   logic [zfs_pkg::WIN_LEN-1:0][zfs_pkg::SAMPLE_BITS-1:0] win_new, win_zero, win_fin;
   logic [zfs_pkg::SEEN_BITS-1:0] seen_ff, seen_in;
   logic [zfs_pkg::SEEN_BITS-1:0] left_ff, left_in;
   logic                          accept;

   assign req_full = (state_ff == zfs_pkg::FRONT_FLUSH) || job_full;
   assign accept   = req_push && !req_full;
   assign win_new  = {win_ff[zfs_pkg::WIN_LEN-2:0], req_sample};
   assign win_zero = {win_ff[zfs_pkg::WIN_LEN-2:0], {zfs_pkg::SAMPLE_BITS{1'b0}}};

   // center the first flush result on the oldest pending sample: shift in
   // one zero for each lead sample a short batch lacks
   always_comb begin
      win_fin = win_new;
      for (int i = 0; i < zfs_pkg::RADIUS; i++) begin
         if (i + int'(seen_ff) < zfs_pkg::RADIUS) begin
            win_fin = {win_fin[zfs_pkg::WIN_LEN-2:0], {zfs_pkg::SAMPLE_BITS{1'b0}}};
         end
      end
   end

   // next state, window update and job issue
   always_comb begin
      state_in      = state_ff;
      win_in        = win_ff;
      seen_in       = seen_ff;
      left_in       = left_ff;
      job_push      = 1'b0;
      job.win       = win_new;
      job.batch_end = 1'b0;
      job.run_end   = 1'b0;
      case (state_ff)
         zfs_pkg::FRONT_RUN: begin
            if (accept) begin
               win_in = win_new;
               if (!req_final_sample) begin
                  if (seen_ff == zfs_pkg::SEEN_BITS'(zfs_pkg::RADIUS)) begin
                     job_push    = 1'b1;
                     job.run_end = 1'b1;
                  end else begin
                     seen_in = seen_ff + 1'b1;
                  end
               end else begin
                  job_push      = 1'b1;
                  job.win       = win_fin;
                  job.batch_end = (seen_ff == '0);
                  job.run_end   = (seen_ff == '0);
                  if (seen_ff == '0) begin
                     win_in = '0;
                  end else begin
                     win_in   = win_fin;
                     left_in  = seen_ff;
                     state_in = zfs_pkg::FRONT_FLUSH;
                  end
               end
            end
         end
         zfs_pkg::FRONT_FLUSH: begin
            job.win = win_zero;
            if (!job_full) begin
               job_push      = 1'b1;
               job.batch_end = (left_ff == zfs_pkg::SEEN_BITS'(1));
               job.run_end   = (left_ff == zfs_pkg::SEEN_BITS'(1));
               left_in       = left_ff - 1'b1;
               if (left_ff == zfs_pkg::SEEN_BITS'(1)) begin
                  win_in   = '0;
                  seen_in  = '0;
                  state_in = zfs_pkg::FRONT_RUN;
               end else begin
                  win_in = win_zero;
               end
            end
         end
         default: begin
            state_in = zfs_pkg::FRONT_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zfs_pkg::FRONT_RUN;
         win_ff   <= '0;
         seen_ff  <= '0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         win_ff   <= win_in;
         seen_ff  <= seen_in;
         left_ff  <= left_in;
      end
   end

   // batch position never passes the radius
   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= zfs_pkg::SEEN_BITS'(zfs_pkg::RADIUS))
      else $error("seen count beyond radius");

   // a flush always has jobs left to issue
   a_flush_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == zfs_pkg::FRONT_FLUSH |-> left_ff != '0)
      else $error("flush with nothing left");

   // the window starts clean after a batch end
   a_clear_after_batch: assert property (@(posedge clock) disable iff (reset)
      job_push && job.batch_end |=> win_ff == '0 && seen_ff == '0)
      else $error("window not cleared after batch");

endmodule

// ===== src/zfs_back.sv =====
// ----------------------------------------------------------------------------
// zfs_back: coefficient bank, dot-product pipeline and result queue
// Multiplies the window by the taps, sums, rounds and saturates, and
// parks results in a small queue; jobs are drawn only when room is assured.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zfs_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [zfs_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [zfs_pkg::COEF_BITS-1:0]           csr_wdata,
   input  zfs_pkg::job_type                        job,
   input  logic                                    job_empty,
   output logic                                    job_pop,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic signed [zfs_pkg::SAMPLE_BITS-1:0]  rsp_smoothed,
   output logic                                    rsp_batch_end,
   output logic                                    rsp_run_end
);

   logic signed [zfs_pkg::COEF_BITS-1:0] tap_ff [zfs_pkg::NUM_TAPS];

   logic signed [zfs_pkg::PROD_BITS-1:0] prod_ff [zfs_pkg::WIN_LEN];
   logic                                 v1_ff, be1_ff, re1_ff;
   logic signed [zfs_pkg::ACC_BITS-1:0]  sum_ff, sum_in;
   logic                                 v2_ff, be2_ff, re2_ff;
   logic signed [zfs_pkg::ACC_BITS-1:0]  rounded;
   logic signed [zfs_pkg::ACC_BITS-1:0]  clipped;

   zfs_pkg::result_type                 out_mem [zfs_pkg::OUT_DEPTH];
   zfs_pkg::result_type                 out_wr;
   logic [zfs_pkg::OUT_PTR_BITS-1:0]    owr_ptr_ff, ord_ptr_ff;
   logic [zfs_pkg::OUT_CNT_BITS-1:0]    ocnt_ff, ocnt_in;
   logic [zfs_pkg::OUT_CNT_BITS:0]      committed;
   logic                                out_rd;

   // coefficient registers; writes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < zfs_pkg::NUM_TAPS; i++) begin
            tap_ff[i] <= zfs_pkg::tap_reset(i);
         end
      end else if (csr_wr_en &&
                   csr_index < zfs_pkg::CSR_IDX_BITS'(zfs_pkg::NUM_TAPS)) begin
         tap_ff[csr_index] <= csr_wdata;
      end
   end

   // draw a job only when queue room covers everything in flight
   assign committed = (zfs_pkg::OUT_CNT_BITS + 1)'(ocnt_ff)
                    + (zfs_pkg::OUT_CNT_BITS + 1)'(v1_ff)
                    + (zfs_pkg::OUT_CNT_BITS + 1)'(v2_ff);
   assign job_pop   = !job_empty &&
                      (committed < (zfs_pkg::OUT_CNT_BITS + 1)'(zfs_pkg::OUT_DEPTH));

   // stage 1: one product per window position, newest sample at index 0
   always_ff @(posedge clock) begin
      for (int j = 0; j < zfs_pkg::WIN_LEN; j++) begin
         prod_ff[j] <= tap_ff[zfs_pkg::TAP_MID + zfs_pkg::RADIUS - j]
                     * $signed(job.win[j]);
      end
      be1_ff <= job.batch_end;
      re1_ff <= job.run_end;
   end

   // stage 2: sum the products
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < zfs_pkg::WIN_LEN; j++) begin
         sum_in = sum_in + zfs_pkg::ACC_BITS'(prod_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      be2_ff <= be1_ff;
      re2_ff <= re1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= job_pop;
         v2_ff <= v1_ff;
      end
   end

   // round half up, drop the fraction, clip to the sample range
   assign rounded = (sum_ff + zfs_pkg::ROUND_BIAS) >>> zfs_pkg::FRAC_BITS;

   always_comb begin
      clipped = rounded;
      if (rounded > zfs_pkg::SAT_HI) begin
         clipped = zfs_pkg::SAT_HI;
      end else if (rounded < zfs_pkg::SAT_LO) begin
         clipped = zfs_pkg::SAT_LO;
      end
   end

   assign out_wr.smoothed  = clipped[zfs_pkg::SAMPLE_BITS-1:0];
   assign out_wr.batch_end = be2_ff;
   assign out_wr.run_end   = re2_ff;

   // result queue
   assign rsp_empty     = (ocnt_ff == '0);
   assign out_rd        = rsp_pop && !rsp_empty;
   assign rsp_smoothed  = out_mem[ord_ptr_ff].smoothed;
   assign rsp_batch_end = out_mem[ord_ptr_ff].batch_end;
   assign rsp_run_end   = out_mem[ord_ptr_ff].run_end;

   always_comb begin
      ocnt_in = ocnt_ff;
      if (v2_ff && !out_rd) begin
         ocnt_in = ocnt_ff + 1'b1;
      end else if (out_rd && !v2_ff) begin
         ocnt_in = ocnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ptr_ff <= '0;
         ord_ptr_ff <= '0;
         ocnt_ff    <= '0;
      end else begin
         if (v2_ff) begin
            owr_ptr_ff <= owr_ptr_ff + 1'b1;
         end
         if (out_rd) begin
            ord_ptr_ff <= ord_ptr_ff + 1'b1;
         end
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         out_mem[owr_ptr_ff] <= out_wr;
      end
   end

   // a finished beat always finds room in the result queue
   a_result_room: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> ocnt_ff < zfs_pkg::OUT_CNT_BITS'(zfs_pkg::OUT_DEPTH))
      else $error("result queue overrun");

endmodule

// ===== src/zero_padded_fir_smoother_top.sv =====
// ----------------------------------------------------------------------------
// zero_padded_fir_smoother_top: centered zero-padded FIR smoother
// Smooths batches of signed samples with seven Q1.15 taps; positions
// outside the batch count as zero, and the final sample flushes the tail.
//
//   channel  ports                              moves
//   req      push/full, sample, final_sample    one sample per beat
//   rsp      empty/pop, smoothed, batch_end,    one result per beat
//            run_end
//   csr      wr_en, index, wdata                one tap write per cycle
//
// Flow: one sample per cycle while full is low; a final sample with s earlier
//   samples in the batch (s up to 3) holds full high while the front shifts
//   zeros in to flush, one job per cycle while the job queue has room.
// Path: job queue, product register, sum register, result queue, then rsp.
// Reset: synchronous; taps return to unity center, window and queues empty.
// Stalls: job and result queues of four beats each decouple the two sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zero_padded_fir_smoother_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic signed [zfs_pkg::SAMPLE_BITS-1:0]  req_sample,
   input  logic                                    req_final_sample,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic signed [zfs_pkg::SAMPLE_BITS-1:0]  rsp_smoothed,
   output logic                                    rsp_batch_end,
   output logic                                    rsp_run_end,
   input  logic                                    csr_wr_en,
   input  logic [zfs_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [zfs_pkg::COEF_BITS-1:0]           csr_wdata
);

   zfs_pkg::job_type fe_job, be_job;
   logic             fe_push, jq_full, jq_empty, be_pop;

   // intake and job issue
   zfs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_sample       (req_sample),
      .req_final_sample (req_final_sample),
      .job_push         (fe_push),
      .job              (fe_job),
      .job_full         (jq_full)
   );

   // decoupling queue
   zfs_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (fe_push),
      .push_job (fe_job),
      .full     (jq_full),
      .pop      (be_pop),
      .pop_job  (be_job),
      .empty    (jq_empty)
   );

   // arithmetic and result queue
   zfs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .job           (be_job),
      .job_empty     (jq_empty),
      .job_pop       (be_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_smoothed  (rsp_smoothed),
      .rsp_batch_end (rsp_batch_end),
      .rsp_run_end   (rsp_run_end)
   );

endmodule

// ===== tb/zero_padded_fir_smoother_top_tb.sv =====
// ----------------------------------------------------------------------------
// zero_padded_fir_smoother_top_tb: self-checking bench for the FIR smoother
// Walks a short directed table (one-sample and short batches, the longest
// flush, saturation under extreme taps), then random batches under three
// idling mixes and several tap sets. Every result is compared field by field
// against an in-bench model of the zero-padded 7-tap window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zero_padded_fir_smoother_top_tb;

   localparam int ITEMS_PER_PHASE = 73;
   localparam int SETTLE_CYCLES   = 12;
   localparam int DIR_ROWS        = 27;

   localparam logic signed [zfs_pkg::SAMPLE_BITS-1:0] SMP_MAX  = 16'sh7FFF;
   localparam logic signed [zfs_pkg::SAMPLE_BITS-1:0] SMP_MIN  = 16'sh8000;
   localparam logic signed [zfs_pkg::COEF_BITS-1:0]   COEF_MAX = 16'sh7FFF;
   localparam logic signed [zfs_pkg::COEF_BITS-1:0]   COEF_MIN = 16'sh8000;

   // coefficient register map; the last index is unmapped
   typedef enum logic [zfs_pkg::CSR_IDX_BITS-1:0] {
      TAP_M3, TAP_M2, TAP_M1, TAP_CTR, TAP_P1, TAP_P2, TAP_P3, TAP_NONE
   } tap_index_type;

   typedef enum logic [1:0] {
      ROW_BEAT,
      ROW_LOAD_MAX,
      ROW_LOAD_MIN
   } row_kind_type;

   typedef struct packed {
      row_kind_type                            kind;
      logic signed [zfs_pkg::SAMPLE_BITS-1:0]  sample;
      logic                                    fin;
      logic                                    typed;
      logic signed [zfs_pkg::SAMPLE_BITS-1:0]  want;
   } dir_row_type;

   typedef logic signed [zfs_pkg::COEF_BITS-1:0] tap_set_type [zfs_pkg::NUM_TAPS];

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_push = 1'b0;
   logic                                    req_full;
   logic signed [zfs_pkg::SAMPLE_BITS-1:0]  req_sample = '0;
   logic                                    req_final_sample = 1'b0;
   logic                                    rsp_empty;
   logic                                    rsp_pop = 1'b0;
   logic signed [zfs_pkg::SAMPLE_BITS-1:0]  rsp_smoothed;
   logic                                    rsp_batch_end;
   logic                                    rsp_run_end;
   logic                                    csr_wr_en = 1'b0;
   logic [zfs_pkg::CSR_IDX_BITS-1:0]        csr_index = '0;
   logic [zfs_pkg::COEF_BITS-1:0]           csr_wdata = '0;

   // model state: window newest first, samples seen this batch, taps
   logic signed [zfs_pkg::SAMPLE_BITS-1:0]  win [zfs_pkg::WIN_LEN];
   int                                      seen;
   logic signed [zfs_pkg::COEF_BITS-1:0]    coef [zfs_pkg::NUM_TAPS];

   zfs_pkg::result_type                     pending_results [$];
   dir_row_type                             dir_rows [DIR_ROWS];
   int                                      mismatches = 0;
   int                                      send_idle_pct = 0;
   int                                      pop_idle_pct = 0;

   zero_padded_fir_smoother_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_sample       (req_sample),
      .req_final_sample (req_final_sample),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_smoothed     (rsp_smoothed),
      .rsp_batch_end    (rsp_batch_end),
      .rsp_run_end      (rsp_run_end),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // weighted sum centered m positions behind the newest sample, rounded
   // and saturated; positions newer than the newest count as zero
   function automatic logic signed [zfs_pkg::SAMPLE_BITS-1:0] window_sum(input int m);
      longint acc;
      longint hi;
      int     offs;
      acc = 0;
      hi  = (longint'(1) <<< (zfs_pkg::SAMPLE_BITS - 1)) - 1;
      for (int k = -zfs_pkg::RADIUS; k <= zfs_pkg::RADIUS; k++) begin
         offs = m - k;
         if (offs >= 0 && offs < zfs_pkg::WIN_LEN) begin
            acc += longint'(win[offs]) * longint'(coef[zfs_pkg::TAP_MID + k]);
         end
      end
      acc = (acc + (longint'(1) <<< (zfs_pkg::FRAC_BITS - 1))) >>> zfs_pkg::FRAC_BITS;
      if (acc > hi) acc = hi;
      if (acc < -hi - 1) acc = -hi - 1;
      return acc[zfs_pkg::SAMPLE_BITS-1:0];
   endfunction

   // writes to an unmapped index leave the taps alone
   function automatic void write_coef(input int idx,
                                      input logic [zfs_pkg::COEF_BITS-1:0] val);
      if (idx < zfs_pkg::NUM_TAPS) begin
         coef[idx] = val;
      end
   endfunction

   function automatic logic signed [zfs_pkg::SAMPLE_BITS-1:0] pick_sample();
      logic signed [zfs_pkg::SAMPLE_BITS-1:0] s;
      case ($urandom_range(9))
         0:       s = SMP_MAX;
         1:       s = SMP_MIN;
         2:       s = '0;
         3:       s = -16'sd1;
         default: s = zfs_pkg::SAMPLE_BITS'($urandom);
      endcase
      return s;
   endfunction

   // advance the window by one accepted beat and queue its results
   task automatic predict_sample(input logic signed [zfs_pkg::SAMPLE_BITS-1:0] s,
                                 input logic fin, input logic typed,
                                 input logic signed [zfs_pkg::SAMPLE_BITS-1:0] want);
      zfs_pkg::result_type r;
      for (int i = zfs_pkg::WIN_LEN - 1; i > 0; i--) begin
         win[i] = win[i - 1];
      end
      win[0] = s;
      if (!fin) begin
         if (seen >= zfs_pkg::RADIUS) begin
            r.smoothed  = typed ? want : window_sum(zfs_pkg::RADIUS);
            r.batch_end = 1'b0;
            r.run_end   = 1'b1;
            pending_results.push_back(r);
         end else begin
            seen++;
         end
      end else begin
         // flush the tail of the batch, then clear the window
         for (int m = seen; m >= 0; m--) begin
            r.smoothed  = typed ? want : window_sum(m);
            r.batch_end = (m == 0);
            r.run_end   = (m == 0);
            pending_results.push_back(r);
         end
         foreach (win[i]) win[i] = '0;
         seen = 0;
      end
   endtask

   // offer one sample beat, with random idle cycles ahead of it
   task automatic send_beat(input logic signed [zfs_pkg::SAMPLE_BITS-1:0] s,
                            input logic fin, input logic typed,
                            input logic signed [zfs_pkg::SAMPLE_BITS-1:0] want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_sample       <= s;
      req_final_sample <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_sample(s, fin, typed, want);
   endtask

   // hold the sender until every expected result is in, then let the pipe settle
   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all seven taps plus one stray write to the unmapped index
   task automatic load_taps(input tap_set_type t);
      drain_results();
      for (int i = 0; i < zfs_pkg::NUM_TAPS; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= tap_index_type'(i);
         csr_wdata <= t[i];
         @(posedge clock);
         write_coef(i, t[i]);
      end
      csr_wr_en <= 1'b1;
      csr_index <= TAP_NONE;
      csr_wdata <= zfs_pkg::COEF_BITS'($urandom);
      @(posedge clock);
      write_coef(TAP_NONE, csr_wdata);
      csr_wr_en <= 1'b0;
   endtask

   task automatic roll_taps(output tap_set_type t);
      int style;
      style = $urandom_range(2);
      foreach (t[i]) begin
         case (style)
            0: t[i] = zfs_pkg::COEF_BITS'($urandom);
            1: t[i] = zfs_pkg::COEF_BITS'($urandom_range(0, 12000));
            default: begin
               case ($urandom_range(4))
                  0:       t[i] = COEF_MAX;
                  1:       t[i] = COEF_MIN;
                  2:       t[i] = '0;
                  3:       t[i] = -16'sd1;
                  default: t[i] = 16'sd1;
               endcase
            end
         endcase
      end
   endtask

   // check each popped result beat against the oldest expectation
   always @(posedge clock) begin : rsp_check
      zfs_pkg::result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result beat: smoothed %0d", rsp_smoothed);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_smoothed !== want.smoothed) begin
                  $error("smoothed: expected %0d, got %0d", $signed(want.smoothed),
                         rsp_smoothed);
                  mismatches++;
               end
               if (rsp_batch_end !== want.batch_end) begin
                  $error("batch_end: expected %0b, got %0b", want.batch_end, rsp_batch_end);
                  mismatches++;
               end
               if (rsp_run_end !== want.run_end) begin
                  $error("run_end: expected %0b, got %0b", want.run_end, rsp_run_end);
                  mismatches++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   initial begin : stimulus
      tap_set_type taps;
      int          len;
      int          sent;

      // one-sample batches with unity center, short and max flushes,
      // then saturation under the largest and smallest taps
      dir_rows = '{
         '{ROW_BEAT, SMP_MAX,    1'b1, 1'b1, 16'sd32766},
         '{ROW_BEAT, SMP_MIN,    1'b1, 1'b1, -16'sd32767},
         '{ROW_BEAT, 16'sd0,     1'b1, 1'b1, 16'sd0},
         '{ROW_BEAT, 16'sd1,     1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, -16'sd1,    1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MAX,    1'b1, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MIN,    1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MAX,    1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MIN,    1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, 16'sd12345, 1'b1, 1'b0, 16'sd0},
         '{ROW_BEAT, 16'sd5,     1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, 16'sd6,     1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, 16'sd7,     1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, 16'sd8,     1'b0, 1'b1, 16'sd5},
         '{ROW_BEAT, 16'sd9,     1'b1, 1'b0, 16'sd0},
         '{ROW_LOAD_MAX, 16'sd0, 1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MAX,    1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MAX,    1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MAX,    1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MAX,    1'b0, 1'b1, 16'sd32767},
         '{ROW_BEAT, SMP_MIN,    1'b1, 1'b0, 16'sd0},
         '{ROW_LOAD_MIN, 16'sd0, 1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MIN,    1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MIN,    1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MIN,    1'b0, 1'b0, 16'sd0},
         '{ROW_BEAT, SMP_MIN,    1'b0, 1'b1, 16'sd32767},
         '{ROW_BEAT, SMP_MAX,    1'b1, 1'b0, 16'sd0}
      };

      // model state after reset: unity center tap, empty window
      foreach (win[i]) win[i] = '0;
      foreach (coef[i]) coef[i] = '0;
      coef[zfs_pkg::TAP_MID] = COEF_MAX;
      seen = 0;

      send_idle_pct = 17;
      pop_idle_pct  = 88;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_rows[r]) begin
         case (dir_rows[r].kind)
            ROW_LOAD_MAX: begin
               foreach (taps[i]) taps[i] = COEF_MAX;
               load_taps(taps);
            end
            ROW_LOAD_MIN: begin
               foreach (taps[i]) taps[i] = COEF_MIN;
               load_taps(taps);
            end
            default: begin
               send_beat(dir_rows[r].sample, dir_rows[r].fin, dir_rows[r].typed,
                         dir_rows[r].want);
            end
         endcase
      end

      // random batches: receiver-idle mix, sender-idle mix, then full rate
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 88 : 0;
         pop_idle_pct  = (ph == 0) ? 88 : (ph == 1) ? 17 : 0;
         roll_taps(taps);
         load_taps(taps);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            len = ($urandom_range(99) < 30) ? $urandom_range(1, 4) : $urandom_range(5, 20);
            for (int j = 0; j < len; j++) begin
               send_beat(pick_sample(), (j == len - 1), 1'b0, '0);
            end
            sent += len;
            if ($urandom_range(7) == 0) begin
               roll_taps(taps);
               load_taps(taps);
            end
         end
      end

      drain_results();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/zfs_pkg.sv
src/zfs_jobq.sv
src/zfs_front.sv
src/zfs_back.sv
src/zero_padded_fir_smoother_top.sv
tb/zero_padded_fir_smoother_top_tb.sv
